FILE: src/clir_pkg.sv
// Package for the cursor list block: state and code enums, field widths and defaults.
// No dependencies; used by cursor_list_insert_remove and clir_checker.
package clir_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int ENTRY_W  = 32;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // slave side: tdata = entry_value, tuser = mode
    localparam int S_TDATA_W = 32;
    // master side: tdata = current_value, item_count, pad; tuser = has_current, status
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1 + STATUS_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_START   = 3'd0,
        MODE_ADVANCE = 3'd1,
        MODE_INSERT  = 3'd2,
        MODE_ATTACH  = 3'd3,
        MODE_REMOVE  = 3'd4,
        MODE_READ    = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_NO_CUR = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_STORE,
        S_FETCH,
        S_OUT
    } t_state;

endpackage

FILE: src/cursor_list_insert_remove.sv
// Ordered word list with a cursor: start, advance, insert, attach, remove, read.
// Depends on clir_pkg; one memory with its own write port and a registered read.
//
// One beat at a time: the block takes a beat, works on it, and drops o_s_tready
// until the result is in the output register. A plain step (start, advance,
// read, or a rejected add or remove) passes through S_FETCH and S_OUT only.
// Insert and attach add an S_SHIFT_RD, S_SHIFT_WR pair for every stored word
// that moves up one place plus S_STORE for writing the new word; remove adds
// a pair for every word behind the removed one. Each move is one read and one
// write through the memory's single registered read port; the worst case is an
// insert at the front of 31 stored words. A result still waiting in the output
// register holds the block in S_OUT until the receiver takes it.
// The list array needs no clearing after reset: only written entries are read.
module cursor_list_insert_remove #(
    parameter int CAPACITY   = clir_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = clir_pkg::WORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [clir_pkg::S_TDATA_W-1:0] i_s_tdata,  // [31:0] entry_value
    input  logic [clir_pkg::MODE_W-1:0]    i_s_tuser,  // [2:0] mode
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] current_value, [37:32] item_count, [39:38] zero
    output logic [clir_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [clir_pkg::M_TUSER_W-1:0] o_m_tuser   // [0] has_current, [2:1] status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [WORD_WIDTH-1:0] mem [0:CAPACITY-1];

    clir_pkg::t_state  r_state, n_state;
    clir_pkg::t_mode   r_mode, n_mode;
    clir_pkg::t_status r_status, n_status;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_cursor, n_cursor;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_pos, n_pos;
    logic [WORD_WIDTH-1:0] r_word, n_word;
    logic [WORD_WIDTH-1:0] r_rd_data;

    logic                          r_out_valid, n_out_valid;
    logic [clir_pkg::VALUE_W-1:0]  r_out_value, n_out_value;
    logic [clir_pkg::COUNT_W-1:0]  r_out_count, n_out_count;
    logic                          r_out_has, n_out_has;
    clir_pkg::t_status             r_out_status, n_out_status;

    logic                  mem_we;
    logic [AW-1:0]         mem_wr_addr;
    logic [WORD_WIDTH-1:0] mem_wr_data;
    logic [AW-1:0]         mem_rd_addr;

    logic                  w_in_acc;
    logic                  w_has;
    logic                  w_full;
    logic                  w_slot_free;
    logic [CW-1:0]         w_cursor_inc;
    logic [CW-1:0]         w_ins_pos;
    logic                  w_rm_shift;
    logic                  w_rm_more;
    logic                  w_ins_more;
    logic [CW-1:0]         w_idx_up;
    logic [CW-1:0]         w_idx_dn;
    logic [WORD_WIDTH+31:0]   w_entry_ext;
    logic [WORD_WIDTH-1:0]    w_entry;
    logic [WORD_WIDTH+31:0]   w_val_ext;
    logic [CW+5:0]            w_count_ext;
    clir_pkg::t_mode          w_in_mode;

    assign w_in_mode    = clir_pkg::t_mode'(i_s_tuser);
    assign w_in_acc     = i_s_tvalid && o_s_tready;
    assign w_has        = r_cursor < r_count;
    assign w_full       = r_count >= CW'(CAPACITY);
    assign w_slot_free  = !r_out_valid || i_m_tready;
    assign w_cursor_inc = r_cursor + 1'b1;
    assign w_idx_up     = r_idx + 1'b1;
    assign w_idx_dn     = r_idx - 1'b1;
    assign w_ins_pos    = !w_has ? '0 :
                          (w_in_mode == clir_pkg::MODE_INSERT) ? r_cursor : w_cursor_inc;
    assign w_rm_shift   = ({1'b0, r_cursor} + 1'b1) < {1'b0, r_count};
    assign w_rm_more    = ({1'b0, r_idx} + 2'd2) < {1'b0, r_count};
    assign w_ins_more   = w_idx_dn > r_pos;
    assign w_entry_ext  = {{WORD_WIDTH{1'b0}}, i_s_tdata};
    assign w_entry      = w_entry_ext[WORD_WIDTH-1:0];
    assign w_val_ext    = {32'b0, r_rd_data};
    assign w_count_ext  = {6'b0, r_count};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            clir_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    case (w_in_mode)
                        clir_pkg::MODE_INSERT, clir_pkg::MODE_ATTACH: begin
                            if (w_full) begin
                                n_state = clir_pkg::S_FETCH;
                            end else if (r_count > w_ins_pos) begin
                                n_state = clir_pkg::S_SHIFT_RD;
                            end else begin
                                n_state = clir_pkg::S_STORE;
                            end
                        end
                        clir_pkg::MODE_REMOVE: begin
                            if (w_has && w_rm_shift) begin
                                n_state = clir_pkg::S_SHIFT_RD;
                            end else begin
                                n_state = clir_pkg::S_FETCH;
                            end
                        end
                        default: n_state = clir_pkg::S_FETCH;
                    endcase
                end
            end
            clir_pkg::S_SHIFT_RD: n_state = clir_pkg::S_SHIFT_WR;
            clir_pkg::S_SHIFT_WR: begin
                if (r_mode == clir_pkg::MODE_REMOVE) begin
                    n_state = w_rm_more ? clir_pkg::S_SHIFT_RD : clir_pkg::S_FETCH;
                end else begin
                    n_state = w_ins_more ? clir_pkg::S_SHIFT_RD : clir_pkg::S_STORE;
                end
            end
            clir_pkg::S_STORE: n_state = clir_pkg::S_FETCH;
            clir_pkg::S_FETCH: n_state = clir_pkg::S_OUT;
            clir_pkg::S_OUT: begin
                if (w_slot_free) begin
                    n_state = clir_pkg::S_IDLE;
                end
            end
            default: n_state = clir_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_mode       = r_mode;
        n_status     = r_status;
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_word       = r_word;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_value  = r_out_value;
        n_out_count  = r_out_count;
        n_out_has    = r_out_has;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_wr_addr  = r_idx[AW-1:0];
        mem_wr_data  = r_rd_data;
        mem_rd_addr  = r_cursor[AW-1:0];
        case (r_state)
            clir_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_mode   = w_in_mode;
                    n_word   = w_entry;
                    n_status = clir_pkg::STATUS_OK;
                    case (w_in_mode)
                        clir_pkg::MODE_START: n_cursor = '0;
                        clir_pkg::MODE_ADVANCE: begin
                            if (w_has) begin
                                n_cursor = w_cursor_inc;
                            end else begin
                                n_status = clir_pkg::STATUS_NO_CUR;
                            end
                        end
                        clir_pkg::MODE_INSERT, clir_pkg::MODE_ATTACH: begin
                            if (w_full) begin
                                n_status = clir_pkg::STATUS_FULL;
                            end else begin
                                n_pos = w_ins_pos;
                                n_idx = r_count;
                            end
                        end
                        clir_pkg::MODE_REMOVE: begin
                            if (w_has) begin
                                n_idx = r_cursor;
                                // removing the tail item: nothing to move
                                if (!w_rm_shift) begin
                                    n_count = r_count - 1'b1;
                                end
                            end else begin
                                n_status = clir_pkg::STATUS_NO_CUR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            clir_pkg::S_SHIFT_RD: begin
                mem_rd_addr = (r_mode == clir_pkg::MODE_REMOVE) ? w_idx_up[AW-1:0]
                                                                : w_idx_dn[AW-1:0];
            end
            clir_pkg::S_SHIFT_WR: begin
                mem_we = 1'b1;
                if (r_mode == clir_pkg::MODE_REMOVE) begin
                    n_idx = w_idx_up;
                    if (!w_rm_more) begin
                        n_count = r_count - 1'b1;
                    end
                end else begin
                    n_idx = w_idx_dn;
                end
            end
            clir_pkg::S_STORE: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_pos[AW-1:0];
                mem_wr_data = r_word;
                n_count     = r_count + 1'b1;
                n_cursor    = r_pos;
            end
            clir_pkg::S_FETCH: ;
            clir_pkg::S_OUT: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_has    = w_has;
                    n_out_value  = w_has ? w_val_ext[clir_pkg::VALUE_W-1:0] : '0;
                    n_out_count  = w_count_ext[clir_pkg::COUNT_W-1:0];
                    n_out_status = r_status;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[mem_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clir_pkg::S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_status     <= n_status;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_word       <= n_word;
        r_out_value  <= n_out_value;
        r_out_count  <= n_out_count;
        r_out_has    <= n_out_has;
        r_out_status <= n_out_status;
    end

    assign o_s_tready = (r_state == clir_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_count, r_out_value};
    assign o_m_tuser  = {r_out_status, r_out_has};

endmodule

FILE: src/clir_checker.sv
// Port-level checks for cursor_list_insert_remove, bound to the top level.
// Depends on clir_pkg for port widths and status codes.
module clir_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [clir_pkg::S_TDATA_W-1:0] i_s_tdata,
    input logic [clir_pkg::MODE_W-1:0]    i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [clir_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [clir_pkg::M_TUSER_W-1:0] o_m_tuser
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // one beat in flight: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted again right after a beat");

    a_no_cur_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[31:0] == 32'd0)
        else $error("nonzero value without a current item");

    a_no_cur_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2:1] == clir_pkg::STATUS_NO_CUR |-> !o_m_tuser[0])
        else $error("missing-cursor status with a current item");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser[2:1] != 2'd3 && o_m_tdata[39:38] == 2'b00)
        else $error("bad status code or padding");

endmodule

bind cursor_list_insert_remove clir_checker u_clir_checker (.*);
